// ----- rtl/rgbhsl_pkg.sv -----
// Shared widths, constants and types for the RGB to HSL converter.
package rgbhsl_pkg;

  localparam int IN_W = 8;
  localparam int HUE_W = 15;
  localparam int PCT_W = 14;

  localparam int HUE_FRAC_BITS_DEF = 6;
  localparam int PCT_FRAC_BITS_DEF = 7;

  localparam int HUE_NUM_W = 17;
  localparam int SAT_NUM_W = 15;
  localparam int LIT_NUM_W = 16;
  localparam int LIT_DEN_W = 9;

  localparam int CHAN_MAX = 255;
  localparam int LIT_DEN = 510;
  localparam int PCT_SCALE = 100;
  localparam int HUE_FULL = 360;
  localparam int DEG_60 = 60;
  localparam int DEG_120 = 120;
  localparam int DEG_240 = 240;
  localparam int DEG_360 = 360;

  typedef enum logic [2:0] {
    HUE_GRAY,
    HUE_RED_POS,
    HUE_RED_NEG,
    HUE_GREEN,
    HUE_BLUE
  } hue_case_t;

endpackage

// ----- rtl/rgbhsl_pix_if.sv -----
// Handshake interface that carries one RGB pixel.
interface rgbhsl_pix_if;
  logic                         valid;
  logic                         ready;
  logic [rgbhsl_pkg::IN_W-1:0]  red;
  logic [rgbhsl_pkg::IN_W-1:0]  green;
  logic [rgbhsl_pkg::IN_W-1:0]  blue;

  modport source(output valid, output red, output green, output blue, input ready);
  modport sink(input valid, input red, input green, input blue, output ready);
endinterface

// ----- rtl/rgbhsl_hsl_if.sv -----
// Handshake interface that carries one HSL result.
interface rgbhsl_hsl_if;
  logic                          valid;
  logic                          ready;
  logic [rgbhsl_pkg::HUE_W-1:0]  hue;
  logic [rgbhsl_pkg::PCT_W-1:0]  saturation;
  logic [rgbhsl_pkg::PCT_W-1:0]  lightness;

  modport source(output valid, output hue, output saturation, output lightness,
                 input ready);
  modport sink(input valid, input hue, input saturation, input lightness,
               output ready);
endinterface

// ----- rtl/rgbhsl_prep.sv -----
// Two front stages: channel extremes, then the dividends of the three quotients and the hue and saturation divisors.
module rgbhsl_prep #(
  parameter int HUE_FRAC_BITS = rgbhsl_pkg::HUE_FRAC_BITS_DEF,
  parameter int PCT_FRAC_BITS = rgbhsl_pkg::PCT_FRAC_BITS_DEF,
  parameter int HNW = rgbhsl_pkg::HUE_NUM_W + HUE_FRAC_BITS,
  parameter int SNW = rgbhsl_pkg::SAT_NUM_W + PCT_FRAC_BITS,
  parameter int LNW = rgbhsl_pkg::LIT_NUM_W + PCT_FRAC_BITS
) (
  input  logic                           clk,
  input  logic [1:0]                     en,
  input  logic [rgbhsl_pkg::IN_W-1:0]    red,
  input  logic [rgbhsl_pkg::IN_W-1:0]    green,
  input  logic [rgbhsl_pkg::IN_W-1:0]    blue,
  output logic [HNW-1:0]                 hue_num,
  output logic [rgbhsl_pkg::IN_W-1:0]    hue_den,
  output logic [SNW-1:0]                 sat_num,
  output logic [rgbhsl_pkg::IN_W-1:0]    sat_den,
  output logic [LNW-1:0]                 lit_num
);

  localparam int InW = rgbhsl_pkg::IN_W;
  localparam int HnW = rgbhsl_pkg::HUE_NUM_W;
  localparam int SnW = rgbhsl_pkg::SAT_NUM_W;
  localparam int LnW = rgbhsl_pkg::LIT_NUM_W;
  localparam int SumW = InW + 1;

  logic [InW-1:0]        mx_nxt, mn_nxt;
  rgbhsl_pkg::hue_case_t sel_nxt;

  logic [InW-1:0]        red_r, green_r, blue_r, mx_r, mn_r;
  rgbhsl_pkg::hue_case_t sel_r;

  logic [InW-1:0]        dlt;
  logic [SumW-1:0]       sum;
  logic [HnW-1:0]        hnum;
  logic [HnW-1:0]        dx, rx, gx, bx;
  logic [SumW-1:0]       far;

  logic [HNW-1:0]        hue_num_nxt;
  logic [InW-1:0]        hue_den_nxt;
  logic [SNW-1:0]        sat_num_nxt;
  logic [InW-1:0]        sat_den_nxt;
  logic [LNW-1:0]        lit_num_nxt;

  logic [HNW-1:0]        hue_num_r;
  logic [InW-1:0]        hue_den_r;
  logic [SNW-1:0]        sat_num_r;
  logic [InW-1:0]        sat_den_r;
  logic [LNW-1:0]        lit_num_r;

  always_comb begin
    mx_nxt = red;
    mn_nxt = red;
    if (green > mx_nxt) mx_nxt = green;
    if (blue > mx_nxt) mx_nxt = blue;
    if (green < mn_nxt) mn_nxt = green;
    if (blue < mn_nxt) mn_nxt = blue;
    if (mx_nxt == mn_nxt) begin
      sel_nxt = rgbhsl_pkg::HUE_GRAY;
    end else if (mx_nxt == red) begin
      sel_nxt = (green >= blue) ? rgbhsl_pkg::HUE_RED_POS : rgbhsl_pkg::HUE_RED_NEG;
    end else if (mx_nxt == green) begin
      sel_nxt = rgbhsl_pkg::HUE_GREEN;
    end else begin
      sel_nxt = rgbhsl_pkg::HUE_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      red_r   <= red;
      green_r <= green;
      blue_r  <= blue;
      mx_r    <= mx_nxt;
      mn_r    <= mn_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    dlt = mx_r - mn_r;
    sum = SumW'(mx_r) + SumW'(mn_r);
    dx  = HnW'(dlt);
    rx  = HnW'(red_r);
    gx  = HnW'(green_r);
    bx  = HnW'(blue_r);
    case (sel_r)
      rgbhsl_pkg::HUE_GRAY:    hnum = '0;
      rgbhsl_pkg::HUE_RED_POS: hnum = HnW'(rgbhsl_pkg::DEG_60) * (gx - bx);
      rgbhsl_pkg::HUE_RED_NEG: hnum = HnW'(rgbhsl_pkg::DEG_360) * dx
                                      - HnW'(rgbhsl_pkg::DEG_60) * (bx - gx);
      rgbhsl_pkg::HUE_GREEN:   hnum = HnW'(rgbhsl_pkg::DEG_120) * dx
                                      + HnW'(rgbhsl_pkg::DEG_60) * bx
                                      - HnW'(rgbhsl_pkg::DEG_60) * rx;
      rgbhsl_pkg::HUE_BLUE:    hnum = HnW'(rgbhsl_pkg::DEG_240) * dx
                                      + HnW'(rgbhsl_pkg::DEG_60) * rx
                                      - HnW'(rgbhsl_pkg::DEG_60) * gx;
      default:                 hnum = '0;
    endcase

    far = SumW'(rgbhsl_pkg::LIT_DEN) - sum;
    hue_num_nxt = HNW'(hnum) << HUE_FRAC_BITS;
    lit_num_nxt = LNW'(LnW'(sum) * LnW'(rgbhsl_pkg::PCT_SCALE)) << PCT_FRAC_BITS;
    if (sel_r == rgbhsl_pkg::HUE_GRAY) begin
      hue_den_nxt = InW'(1);
      sat_num_nxt = '0;
      sat_den_nxt = InW'(1);
    end else begin
      hue_den_nxt = dlt;
      sat_num_nxt = SNW'(SnW'(dlt) * SnW'(rgbhsl_pkg::PCT_SCALE)) << PCT_FRAC_BITS;
      sat_den_nxt = (sum <= SumW'(rgbhsl_pkg::CHAN_MAX)) ? sum[InW-1:0] : far[InW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      hue_num_r <= hue_num_nxt;
      hue_den_r <= hue_den_nxt;
      sat_num_r <= sat_num_nxt;
      sat_den_r <= sat_den_nxt;
      lit_num_r <= lit_num_nxt;
    end
  end

  assign hue_num = hue_num_r;
  assign hue_den = hue_den_r;
  assign sat_num = sat_num_r;
  assign sat_den = sat_den_r;
  assign lit_num = lit_num_r;

endmodule

// ----- rtl/rgbhsl_div_cell.sv -----
// One restoring division step that yields a single quotient bit.
module rgbhsl_div_cell #(
  parameter int DW = rgbhsl_pkg::IN_W,
  parameter int QW = rgbhsl_pkg::HUE_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [DW-1:0] den_i,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] low_o,
  output logic [DW-1:0] den_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          take;
  logic [DW-1:0] rem_nxt;
  logic [QW-1:0] low_nxt;

  logic [DW-1:0] rem_r;
  logic [QW-1:0] low_r;
  logic [DW-1:0] den_r;

  always_comb begin
    trial   = {rem_i, low_i[QW-1]};
    diff    = trial - {1'b0, den_i};
    take    = trial >= {1'b0, den_i};
    rem_nxt = take ? diff[DW-1:0] : trial[DW-1:0];
    low_nxt = {low_i[QW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
      den_r <= den_i;
    end
  end

  assign rem_o = rem_r;
  assign low_o = low_r;
  assign den_o = den_r;

endmodule

// ----- rtl/rgbhsl_div_chain.sv -----
// Row of division cells that turns a dividend and divisor into a QW-bit quotient.
module rgbhsl_div_chain #(
  parameter int DW = rgbhsl_pkg::IN_W,
  parameter int NW = rgbhsl_pkg::HUE_NUM_W,
  parameter int QW = rgbhsl_pkg::HUE_W
) (
  input  logic          clk,
  input  logic [QW-1:0] en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quot
);

  logic [DW-1:0] rem_w [QW+1];
  logic [QW-1:0] low_w [QW+1];
  logic [DW-1:0] den_w [QW+1];

  assign rem_w[0] = DW'(num >> QW);
  assign low_w[0] = num[QW-1:0];
  assign den_w[0] = den;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    rgbhsl_div_cell #(
      .DW(DW),
      .QW(QW)
    ) u_cell (
      .clk  (clk),
      .en   (en[k]),
      .rem_i(rem_w[k]),
      .low_i(low_w[k]),
      .den_i(den_w[k]),
      .rem_o(rem_w[k+1]),
      .low_o(low_w[k+1]),
      .den_o(den_w[k+1])
    );
  end

  assign quot = low_w[QW];

endmodule

// ----- rtl/rgb_to_hsl_convert.sv -----
// Top level of the RGB to HSL converter: front stages, three divider chains and flow control.
// One pixel enters per clock unless the pipeline is full and its output stalled. Two front
// stages find the channel extremes and form the dividends, then the restoring divider chains
// resolve one quotient bit per cell into a QB-bit quotient, QB being the quotient width of
// the widest result (15 bits at the default fraction widths). Every stage holds its own valid
// bit and advances into an empty slot, so a stalled output only blocks input once the whole
// pipeline is full.
module rgb_to_hsl_convert #(
  parameter int HUE_FRAC_BITS = rgbhsl_pkg::HUE_FRAC_BITS_DEF,
  parameter int PCT_FRAC_BITS = rgbhsl_pkg::PCT_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rgbhsl_pix_if.sink   in_pix,
  rgbhsl_hsl_if.source out_hsl
);

  localparam int InW    = rgbhsl_pkg::IN_W;
  localparam int HueW   = rgbhsl_pkg::HUE_W;
  localparam int PctW   = rgbhsl_pkg::PCT_W;
  localparam int HueLim = rgbhsl_pkg::HUE_FULL << HUE_FRAC_BITS;
  localparam int PctLim = rgbhsl_pkg::PCT_SCALE << PCT_FRAC_BITS;
  localparam int HueQ   = $clog2(HueLim + 1);
  localparam int PctQ   = $clog2(PctLim + 1);
  localparam int QB     = (HueQ > PctQ) ? HueQ : PctQ;
  localparam int HNR    = rgbhsl_pkg::HUE_NUM_W + HUE_FRAC_BITS;
  localparam int SNR    = rgbhsl_pkg::SAT_NUM_W + PCT_FRAC_BITS;
  localparam int LNR    = rgbhsl_pkg::LIT_NUM_W + PCT_FRAC_BITS;
  localparam int HNW    = (HNR > QB) ? HNR : QB;
  localparam int SNW    = (SNR > QB) ? SNR : QB;
  localparam int LNW    = (LNR > QB) ? LNR : QB;
  localparam int LdW    = rgbhsl_pkg::LIT_DEN_W;
  localparam int Stages = QB + 2;

  logic [Stages-1:0] valid_r;
  logic [Stages-1:0] load;
  logic [Stages-1:0] next_ready;
  logic [Stages-1:0] valid_in;

  logic [HNW-1:0] hue_num;
  logic [InW-1:0] hue_den;
  logic [SNW-1:0] sat_num;
  logic [InW-1:0] sat_den;
  logic [LNW-1:0] lit_num;

  logic [QB-1:0] q_hue;
  logic [QB-1:0] q_sat;
  logic [QB-1:0] q_lit;

  for (genvar k = 0; k < Stages; k++) begin : g_flow
    if (k == Stages - 1) begin : g_last
      assign next_ready[k] = out_hsl.ready;
    end else begin : g_mid
      assign next_ready[k] = load[k+1];
    end
    assign load[k] = !valid_r[k] || next_ready[k];
  end

  assign valid_in = {valid_r[Stages-2:0], in_pix.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (load[k]) valid_r[k] <= valid_in[k];
      end
    end
  end

  rgbhsl_prep #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS),
    .PCT_FRAC_BITS(PCT_FRAC_BITS),
    .HNW(HNW),
    .SNW(SNW),
    .LNW(LNW)
  ) u_prep (
    .clk    (clk),
    .en     (load[1:0]),
    .red    (in_pix.red),
    .green  (in_pix.green),
    .blue   (in_pix.blue),
    .hue_num(hue_num),
    .hue_den(hue_den),
    .sat_num(sat_num),
    .sat_den(sat_den),
    .lit_num(lit_num)
  );

  rgbhsl_div_chain #(
    .DW(InW),
    .NW(HNW),
    .QW(QB)
  ) u_hue_div (
    .clk (clk),
    .en  (load[Stages-1:2]),
    .num (hue_num),
    .den (hue_den),
    .quot(q_hue)
  );

  rgbhsl_div_chain #(
    .DW(InW),
    .NW(SNW),
    .QW(QB)
  ) u_sat_div (
    .clk (clk),
    .en  (load[Stages-1:2]),
    .num (sat_num),
    .den (sat_den),
    .quot(q_sat)
  );

  rgbhsl_div_chain #(
    .DW(LdW),
    .NW(LNW),
    .QW(QB)
  ) u_lit_div (
    .clk (clk),
    .en  (load[Stages-1:2]),
    .num (lit_num),
    .den (LdW'(rgbhsl_pkg::LIT_DEN)),
    .quot(q_lit)
  );

  assign in_pix.ready       = load[0];
  assign out_hsl.valid      = valid_r[Stages-1];
  assign out_hsl.hue        = HueW'(q_hue);
  assign out_hsl.saturation = PctW'(q_sat);
  assign out_hsl.lightness  = PctW'(q_lit);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (valid_r == '0))
    else $error("Pipeline holds a valid item right after reset.");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> ($countones(valid_r) == Stages))
    else $error("Input is blocked while the pipeline still has an empty stage.");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_hsl.valid |-> (32'(q_hue) <= HueLim))
    else $error("Hue quotient exceeds the full circle.");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_hsl.valid |-> ((32'(q_sat) <= PctLim) && (32'(q_lit) <= PctLim)))
    else $error("Saturation or lightness quotient exceeds one hundred percent.");

endmodule
